[rtl/boolean_bit_compress_packer_top_macros.svh]
// ----------------------------------------------------------------------------
// Boolean bit compress packer: assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in rst.
// ----------------------------------------------------------------------------
`ifndef BOOLEAN_BIT_COMPRESS_PACKER_TOP_MACROS_SVH
`define BOOLEAN_BIT_COMPRESS_PACKER_TOP_MACROS_SVH

// Same-cycle implication.
`define BBCP_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bbcp: same-cycle check failed");

// Next-cycle implication.
`define BBCP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bbcp: next-cycle check failed");

`endif

[rtl/bbcp_pkg.sv]
// ----------------------------------------------------------------------------
// Boolean bit compress packer: package
// Word widths and the word types passed between the parts of the packer.
// ----------------------------------------------------------------------------
package bbcp_pkg;

  localparam int WORD_BITS = 16;
  localparam int POS_W     = $clog2(WORD_BITS);
  localparam int CNT_W     = POS_W + 1;

  typedef struct packed {
    logic [WORD_BITS-1:0] mask_word;
    logic [WORD_BITS-1:0] source_word;
    logic                 last_word;
  } in_t;

  typedef struct packed {
    logic [WORD_BITS-1:0] packed_word;
    logic [CNT_W-1:0]     bit_count;
    logic                 final_result;
  } out_t;

  // Compacted word: selected bits gathered at the bottom, their count, end mark.
  typedef struct packed {
    logic [WORD_BITS-1:0] bits;
    logic [CNT_W-1:0]     count;
    logic                 last;
  } comp_t;

endpackage

[rtl/bbcp_front.sv]
// ----------------------------------------------------------------------------
// Boolean bit compress packer: front end
// Accept an input word and gather its selected source bits to the bottom.
// ----------------------------------------------------------------------------
module bbcp_front (
  input  logic          item_valid,
  input  bbcp_pkg::in_t item,
  input  logic          q_full,
  output logic          item_stall,
  output logic          push,
  output bbcp_pkg::comp_t push_data
);
  import bbcp_pkg::*;

  logic [POS_W-1:0]     pos [WORD_BITS];
  logic [WORD_BITS-1:0] bits;

  // Destination of each source bit: number of selected bits below it.
  always_comb begin
    for (int i = 0; i < WORD_BITS; i++) begin
      pos[i] = POS_W'($countones(item.mask_word &
                                 ((WORD_BITS'(1) << i) - WORD_BITS'(1))));
    end
  end

  always_comb begin
    bits = '0;
    for (int i = 0; i < WORD_BITS; i++) begin
      if (item.mask_word[i] && item.source_word[i]) begin
        bits[pos[i]] = 1'b1;
      end
    end
  end

  assign item_stall      = q_full;
  assign push            = item_valid && !q_full;
  assign push_data.bits  = bits;
  assign push_data.count = CNT_W'($countones(item.mask_word));
  assign push_data.last  = item.last_word;

endmodule

[rtl/bbcp_queue.sv]
// ----------------------------------------------------------------------------
// Boolean bit compress packer: decoupling queue
// Two-entry queue of compacted words between front and back end.
// ----------------------------------------------------------------------------
module bbcp_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  bbcp_pkg::comp_t push_data,
  input  logic            pop,
  output logic            q_valid,
  output bbcp_pkg::comp_t q_data,
  output logic            q_full
);
  import bbcp_pkg::*;

  comp_t       entries [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  assign q_valid = (count != 2'd0);
  assign q_full  = (count == 2'd2);
  assign q_data  = entries[rd_ptr];

endmodule

[rtl/bbcp_back.sv]
// ----------------------------------------------------------------------------
// Boolean bit compress packer: back end
// Append compacted bits to the pending word, emit full and flushed words.
// ----------------------------------------------------------------------------
`include "boolean_bit_compress_packer_top_macros.svh"

module bbcp_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            q_valid,
  input  bbcp_pkg::comp_t q_data,
  output logic            pop,
  output logic            result_valid,
  input  logic            result_stall,
  output bbcp_pkg::out_t  result
);
  import bbcp_pkg::*;

  logic [WORD_BITS-1:0]   pending_bits;
  logic [POS_W-1:0]       pending_count;
  logic                   hold_valid;
  out_t                   hold;

  logic                   out_free;
  logic [2*WORD_BITS-1:0] combined;
  logic [CNT_W-1:0]       total;
  logic                   has_full;
  logic                   has_part;
  logic [POS_W-1:0]       rem_count;
  logic [WORD_BITS-1:0]   rem_bits;
  out_t                   r_full;
  out_t                   r_part;

  assign out_free = !result_valid || !result_stall;
  assign pop      = q_valid && out_free && !hold_valid;

  // Concatenate new bits above the pending ones.
  assign combined  = {{WORD_BITS{1'b0}}, pending_bits} |
                     ({{WORD_BITS{1'b0}}, q_data.bits} << pending_count);
  assign total     = {1'b0, pending_count} + q_data.count;
  assign has_full  = total[CNT_W-1];
  assign rem_count = total[POS_W-1:0];
  assign rem_bits  = has_full ? combined[2*WORD_BITS-1:WORD_BITS]
                              : combined[WORD_BITS-1:0];
  assign has_part  = q_data.last && (rem_count != '0);

  assign r_full.packed_word  = combined[WORD_BITS-1:0];
  assign r_full.bit_count    = CNT_W'(WORD_BITS);
  assign r_full.final_result = q_data.last && (rem_count == '0);
  assign r_part.packed_word  = rem_bits;
  assign r_part.bit_count    = {1'b0, rem_count};
  assign r_part.final_result = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending_bits  <= '0;
      pending_count <= '0;
      result_valid  <= 1'b0;
      hold_valid    <= 1'b0;
    end else begin
      if (pop) begin
        // drop the pending word at the end of a vector
        pending_bits  <= q_data.last ? '0 : rem_bits;
        pending_count <= q_data.last ? '0 : rem_count;
      end
      if (hold_valid && out_free) begin
        result_valid <= 1'b1;
        hold_valid   <= 1'b0;
      end else if (pop) begin
        result_valid <= has_full || has_part;
        hold_valid   <= has_full && has_part;
      end else if (out_free) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (hold_valid && out_free) begin
      result <= hold;
    end else if (pop) begin
      result <= has_full ? r_full : r_part;
      hold   <= r_part;
    end
  end

  `BBCP_ASSERT_IMPL(a_hold_behind_out, hold_valid, result_valid)
  `BBCP_ASSERT_IMPL(a_nonfinal_full, result_valid && !result.final_result,
                    result.bit_count == CNT_W'(WORD_BITS))
  `BBCP_ASSERT_IMPL(a_unused_zero, result_valid,
                    (result.packed_word >> result.bit_count) == '0)
  `BBCP_ASSERT_NEXT(a_hold_kept, hold_valid && result_stall, hold_valid)

endmodule

[rtl/boolean_bit_compress_packer_top.sv]
// ----------------------------------------------------------------------------
// Boolean bit compress packer: top level
// Streams mask/source word pairs in and packed selected-bit words out.
// ----------------------------------------------------------------------------
// Each accepted word keeps the source bits whose mask bits are set, lowest
// first, and appends them to a packed bit stream; every completed 16-bit
// word is emitted with bit_count 16, and a word marked last_word also
// flushes the partial word (unused bits zero) with final_result set. A
// vector whose tail leaves nothing pending and completes no word ends with
// no result. One word is accepted per clock while the queue is not full; a
// result passes a queue entry, then the output register. A word that both
// completes a full word and flushes a partial one yields two results, and the
// single output register delivers them in turn, the second waiting in a hold
// register, so the back end takes no new word while it waits; the two-entry
// queue absorbs new words on the input side.
module boolean_bit_compress_packer_top (
  input  logic           clk,
  input  logic           rst,
  input  logic           item_valid,
  output logic           item_stall,
  input  bbcp_pkg::in_t  item,
  output logic           result_valid,
  input  logic           result_stall,
  output bbcp_pkg::out_t result
);
  import bbcp_pkg::*;

  logic  push;
  comp_t push_data;
  logic  pop;
  logic  q_valid;
  comp_t q_data;
  logic  q_full;

  // Compact the incoming word; stall only when the queue is full.
  bbcp_front u_front (
    .item_valid (item_valid),
    .item       (item),
    .q_full     (q_full),
    .item_stall (item_stall),
    .push       (push),
    .push_data  (push_data)
  );

  // Decouple compaction from packing so each side can stall on its own.
  bbcp_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .q_valid   (q_valid),
    .q_data    (q_data),
    .q_full    (q_full)
  );

  // Pack into words, hold a second result while the first waits.
  bbcp_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .q_data       (q_data),
    .pop          (pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

[tb/boolean_bit_compress_packer_top_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Boolean bit compress packer: testbench
// Drives mask/source words through the packer and checks every packed result
// word against a cycle-free software copy of the compaction and packing, under
// phases of sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module boolean_bit_compress_packer_top_tb;
  import bbcp_pkg::*;

  localparam int CLK_PERIOD   = 12;
  localparam int RESET_CYCLES = 12;
  localparam int QUIET_LIMIT  = 4000;  // cycles with no word moving on either side
  localparam int DRAIN_CYCLES = 10;    // slack for stray results after the drain
  localparam int PHASE_WORDS  = 150;

  logic clk;
  logic rst;
  logic item_valid;
  logic item_stall;
  in_t  item;
  logic result_valid;
  logic result_stall = 1'b0;
  out_t result;

  // Idle and stall odds in percent, set per phase.
  int idle_pct  = 0;
  int stall_pct = 0;
  int err_cnt   = 0;
  int quiet_cycles;

  // Software copy of the packer state: bits gathered so far and their count.
  logic [WORD_BITS-1:0] acc_bits;
  int                   acc_count;

  // Packed words still owed by the block, oldest first.
  out_t packed_exp_q[$];

  boolean_bit_compress_packer_top u_top (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // Receiver side: decide the stall for the coming edge on every falling edge.
  always @(negedge clk) begin
    result_stall <= ($urandom_range(99) < stall_pct);
  end

  // Gather the selected source bits, lowest first, into the pending word.
  // Emit a full word whenever 16 bits are in hand; on the last word of a
  // vector flush what is left, or mark the full word just emitted as final.
  task automatic compress_and_pack(input in_t w);
    out_t r;
    int   emitted;
    emitted = 0;
    for (int i = 0; i < WORD_BITS; i++) begin
      if (w.mask_word[i]) begin
        acc_bits[acc_count] = w.source_word[i];
        acc_count++;
        if (acc_count == WORD_BITS) begin
          r.packed_word  = acc_bits;
          r.bit_count    = CNT_W'(WORD_BITS);
          r.final_result = 1'b0;
          packed_exp_q.push_back(r);
          emitted++;
          acc_bits  = '0;
          acc_count = 0;
        end
      end
    end
    if (w.last_word) begin
      if (acc_count != 0) begin
        r.packed_word  = acc_bits;
        r.bit_count    = CNT_W'(acc_count);
        r.final_result = 1'b1;
        packed_exp_q.push_back(r);
      end else if (emitted > 0) begin
        // The word that closed exactly on the boundary ends the vector.
        r = packed_exp_q.pop_back();
        r.final_result = 1'b1;
        packed_exp_q.push_back(r);
      end
      // An empty tail leaves nothing to send and no final mark at all.
      acc_bits  = '0;
      acc_count = 0;
    end
  endtask

  // Offer one word, hold it until taken, then predict its results.
  // Called and returns on a falling edge; valid only ever rises or falls once
  // per edge, and a held word never changes.
  task automatic send_word(input in_t w);
    while ($urandom_range(99) < idle_pct) begin
      item_valid <= 1'b0;
      @(negedge clk);
    end
    item_valid <= 1'b1;
    item       <= w;
    do @(posedge clk); while (item_stall);
    compress_and_pack(w);
    @(negedge clk);
  endtask

  // Drop valid and hold off until every owed packed word has come out.
  task automatic wait_drained();
    item_valid <= 1'b0;
    @(negedge clk);
    while (packed_exp_q.size() != 0) @(negedge clk);
  endtask

  // Send vectors of random length with mixed mask densities; most end cleanly
  // on their last word, a few have the end mark dropped or thrown in early.
  // Halfway through, pause mid-vector until the block has nothing left to say.
  task automatic run_random_vectors(input int n_words);
    int   sent;
    int   vec_len;
    in_t  w;
    sent = 0;
    while (sent < n_words) begin
      if ($urandom_range(9) == 0) vec_len = $urandom_range(9, 40);
      else vec_len = $urandom_range(1, 6);
      for (int k = 0; k < vec_len && sent < n_words; k++) begin
        case ($urandom_range(5))
          0:       w.mask_word = '1;
          1:       w.mask_word = '0;
          2:       w.mask_word = WORD_BITS'($urandom) & WORD_BITS'($urandom)
                                 & WORD_BITS'($urandom);
          3:       w.mask_word = WORD_BITS'($urandom) | WORD_BITS'($urandom);
          default: w.mask_word = WORD_BITS'($urandom);
        endcase
        w.source_word = WORD_BITS'($urandom);
        w.last_word   = (k == vec_len - 1);
        if ($urandom_range(19) == 0) w.last_word = ~w.last_word;
        send_word(w);
        sent++;
        if (sent == n_words / 2) wait_drained();
      end
    end
    wait_drained();
  endtask

  // Corners: empty masks, full masks, an empty tail, a word closing exactly
  // at the end, a full word plus a flush from one input, single and
  // top-bit selections, and a 15-bit flush.
  task automatic test_directed_corners();
    in_t w;
    w = '{16'h0000, 16'hFFFF, 1'b0}; send_word(w);  // nothing kept
    w = '{16'h0000, 16'h0000, 1'b1}; send_word(w);  // empty tail, no result
    w = '{16'hFFFF, 16'hFFFF, 1'b0}; send_word(w);  // full word of ones
    w = '{16'hFFFF, 16'h0000, 1'b1}; send_word(w);  // full word ends the vector
    w = '{16'h00FF, 16'h00A5, 1'b0}; send_word(w);  // eight pending
    w = '{16'hFFFF, 16'h5A5A, 1'b1}; send_word(w);  // full word then 8-bit flush
    w = '{16'h0001, 16'h0001, 1'b1}; send_word(w);  // one-bit flush
    w = '{16'h8000, 16'h8000, 1'b0}; send_word(w);
    w = '{16'h8000, 16'h0000, 1'b1}; send_word(w);  // two-bit flush
    w = '{16'hAAAA, 16'hFFFF, 1'b0}; send_word(w);
    w = '{16'h5555, 16'h5555, 1'b0}; send_word(w);  // completes a word
    w = '{16'h0000, 16'hFFFF, 1'b1}; send_word(w);  // empty tail after a full word
    w = '{16'hFFFF, 16'h8001, 1'b0}; send_word(w);
    w = '{16'h7FFF, 16'h1234, 1'b0}; send_word(w);  // fifteen pending
    w = '{16'h0003, 16'h0002, 1'b1}; send_word(w);  // full word then 1-bit flush
    w = '{16'hFFFE, 16'hFFFF, 1'b1}; send_word(w);  // fifteen-bit flush
    wait_drained();
  endtask

  task automatic test_stream_no_idle();
    idle_pct  = 0;
    stall_pct = 0;
    run_random_vectors(PHASE_WORDS);
  endtask

  task automatic test_stream_sender_gaps();
    idle_pct  = 53;
    stall_pct = 0;
    run_random_vectors(PHASE_WORDS);
  endtask

  task automatic test_stream_receiver_stalls();
    idle_pct  = 0;
    stall_pct = 53;
    run_random_vectors(PHASE_WORDS);
  endtask

  task automatic test_stream_both_idle();
    idle_pct  = 17;
    stall_pct = 17;
    run_random_vectors(PHASE_WORDS);
  endtask

  // Compare every accepted result word, field by field, with the oldest
  // prediction; a result word with nothing owed is a failure too.
  always @(posedge clk) begin : check_results
    out_t want;
    if (!rst && result_valid && !result_stall) begin
      if (packed_exp_q.size() == 0) begin
        $display("%0t: unexpected result word %h count %0d final %0b", $time,
                 result.packed_word, result.bit_count, result.final_result);
        err_cnt++;
      end else begin
        want = packed_exp_q.pop_front();
        if (result.packed_word !== want.packed_word) begin
          $display("%0t: packed_word expected %h, got %h", $time,
                   want.packed_word, result.packed_word);
          err_cnt++;
        end
        if (result.bit_count !== want.bit_count) begin
          $display("%0t: bit_count expected %0d, got %0d", $time,
                   want.bit_count, result.bit_count);
          err_cnt++;
        end
        if (result.final_result !== want.final_result) begin
          $display("%0t: final_result expected %0b, got %0b", $time,
                   want.final_result, result.final_result);
          err_cnt++;
        end
      end
    end
  end

  // Watchdog: end the run if no word moves on either side for too long.
  initial begin
    quiet_cycles = 0;
    while (quiet_cycles < QUIET_LIMIT) begin
      @(posedge clk);
      if (rst || (item_valid && !item_stall) || (result_valid && !result_stall))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("boolean_bit_compress_packer_top_tb NOT OK");
    $finish;
  end

  initial begin
    rst        = 1'b1;
    item_valid = 1'b0;
    item       = '0;
    acc_bits   = '0;
    acc_count  = 0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_directed_corners();
    test_stream_no_idle();
    test_stream_sender_gaps();
    test_stream_receiver_stalls();
    test_stream_both_idle();

    // Let any stray output surface before the verdict.
    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (err_cnt == 0) begin
      $display("boolean_bit_compress_packer_top_tb OK");
    end else begin
      $display("boolean_bit_compress_packer_top_tb NOT OK");
    end
    $finish;
  end

endmodule
